// ----- hw/rtl/pcn_pkg.sv -----
package pcn_pkg;

	// Channel count and the index width of the calibration store
	localparam int CHANNELS = 16;
	localparam int CH_W     = 4;
	localparam int DEPTH    = (CHANNELS < (2 ** CH_W)) ? CHANNELS : (2 ** CH_W);
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Datapath widths
	localparam int SAMPLE_W = 10;
	localparam int PCT_W    = 7;
	localparam int PROD_W   = 17;
	localparam int QUO_W    = 7;
	localparam int STEP_W   = $clog2(QUO_W);
	localparam int DSH_W    = SAMPLE_W + QUO_W - 1;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;
	localparam logic [PCT_W-1:0]    PCT_MAX    = 7'd100;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_NORM   = 2'd0,
		FUNC_CAP_LO = 2'd1,
		FUNC_CAP_HI = 2'd2
	} func_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [CH_W-1:0]     channel;
		logic                inverted_source;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [PCT_W-1:0]    percent;
		logic [SAMPLE_W-1:0] raw_used;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
	} cal_entry_t;

	localparam cal_entry_t CAL_RESET = '{lo: '0, hi: FULL_SCALE};

	// Write request into the calibration store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		cal_entry_t        data;
	} cal_wr_t;

endpackage

// ----- hw/rtl/pcn_cal_mem.sv -----
module pcn_cal_mem
	import pcn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output cal_entry_t        rd_data,
	input  cal_wr_t           wr
);

	cal_entry_t              mem [DEPTH];
	logic       [DEPTH-1:0]  valid_q;
	cal_entry_t              rd_data_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Store array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read; an unwritten entry reads as the reset calibration
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : CAL_RESET;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/pcn_divider.sv -----
module pcn_divider
	import pcn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [SAMPLE_W-1:0] divisor,
	output logic                busy,
	output logic [QUO_W-1:0]    quotient
);

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [PROD_W-1:0]   rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [QUO_W-1:0]    quo_q;
	logic                fits;

	assign fits = rem_q >= PROD_W'(dsh_q);

	// Control: one quotient bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(QUO_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Restoring subtract with a right-shifting divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - PROD_W'(dsh_q);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/per_channel_calibrated_normalizer.sv -----
// Per-channel calibrated normalizer. Each transfer carries an operation, a
// channel and a ten-bit sample (optionally inverted as 1023 minus sample).
// Normalize maps the sample onto 0..100 percent between the channel's stored
// low and high calibration; capture-low and capture-high store the sample.
// Exactly one result comes back per item, in order. Items are handled one at
// a time: a capture, a reserved code or a normalize that clamps to 0 or 100
// passes from lookup straight to finish; a normalize that needs a division
// waits in between on the seven-step serial divider. The calibration store
// read is registered, and the store is written back in place. A finished
// result sits in an output register, so the next item is accepted while it
// waits to be taken. After reset, low is 0 and high is 1023 for every
// channel; no clearing pass is needed.
module per_channel_calibrated_normalizer
	import pcn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	state_t              state_q, state_d;
	logic [1:0]          func_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                ok_q;
	logic [SAMPLE_W-1:0] raw_q;
	logic [PCT_W-1:0]    pct_q, pct_d;
	logic                pct_en;
	logic                out_valid_q;
	out_item_t           out_q;
	logic                load_out;

	logic                accept;
	logic                rd_en;
	logic [SAMPLE_W-1:0] raw_in;
	logic                ok_in;
	cal_entry_t          rd_data;
	cal_wr_t             wr;
	logic [SAMPLE_W-1:0] lo_w, hi_w;
	logic                div_start, div_busy;
	logic [PROD_W-1:0]   dividend;
	logic [SAMPLE_W-1:0] divisor;
	logic [QUO_W-1:0]    quotient;

	assign accept = in_valid && in_ready;
	assign raw_in = in_data.inverted_source ? (FULL_SCALE - in_data.sample) : in_data.sample;
	assign ok_in  = 7'(in_data.channel) < 7'(CHANNELS);

	// Out-of-range channels see the reset calibration
	assign lo_w = ok_q ? rd_data.lo : CAL_RESET.lo;
	assign hi_w = ok_q ? rd_data.hi : CAL_RESET.hi;

	assign dividend = PROD_W'(raw_q - lo_w) * PROD_W'(PCT_MAX);
	assign divisor  = hi_w - lo_w;

	pcn_cal_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (ADDR_W'(in_data.channel)),
		.rd_data (rd_data),
		.wr      (wr)
	);

	pcn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store access, divider start and result load
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		wr        = '0;
		div_start = 1'b0;
		pct_en    = 1'b0;
		pct_d     = '0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				pct_en  = 1'b1;
				state_d = ST_FIN;
				wr.addr = addr_q;
				case (func_q)
					FUNC_NORM: begin
						if (raw_q <= lo_w) begin
							pct_d = '0;
						end else if (raw_q >= hi_w) begin
							pct_d = PCT_MAX;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					FUNC_CAP_LO: begin
						wr.en   = ok_q;
						wr.data = '{lo: raw_q, hi: rd_data.hi};
					end
					FUNC_CAP_HI: begin
						wr.en   = ok_q;
						wr.data = '{lo: rd_data.lo, hi: raw_q};
					end
					default: begin
						pct_d = '0;
					end
				endcase
			end
			ST_DIV: begin
				if (!div_busy) begin
					pct_en  = 1'b1;
					pct_d   = PCT_W'(quotient);
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the accepted item and the computed percent
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_data.func;
			addr_q <= ADDR_W'(in_data.channel);
			ok_q   <= ok_in;
			raw_q  <= raw_in;
		end
		if (pct_en) begin
			pct_q <= pct_d;
		end
	end

	// Output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= '{percent: pct_q, raw_used: raw_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/pcn_check.sv -----
module pcn_check
	import pcn_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Percent never exceeds 100
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.percent <= PCT_MAX)
		else $error("percent above 100");

	// One item in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in flight");

	// A new result appears only while an item is being worked on
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without item in flight");

endmodule

bind per_channel_calibrated_normalizer pcn_check u_check (.*);
